[design/prs80_pkg.sv]
// Shared types, constants and round functions of the PRESENT-80 cipher.
// No dependencies; imported by every module of the block.
`default_nettype none

package prs80_pkg;

   localparam int BLOCK_W   = 64;
   localparam int KEY_W     = 80;
   localparam int KEY_HI_W  = 16;
   localparam int RC_W      = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 2'd1;

   localparam logic [3:0] SBOX_FWD [16] = '{
      4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
      4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
   };

   localparam logic [3:0] SBOX_INV [16] = '{
      4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
      4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
   };

   typedef struct packed {
      logic valid;
      logic mode;
   } stage_ctl_type;

   function automatic logic [BLOCK_W-1:0] sub_layer_fwd(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] r;
      for (int n = 0; n < 16; n++) begin
         r[4*n +: 4] = SBOX_FWD[s[4*n +: 4]];
      end
      return r;
   endfunction

   function automatic logic [BLOCK_W-1:0] sub_layer_inv(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] r;
      for (int n = 0; n < 16; n++) begin
         r[4*n +: 4] = SBOX_INV[s[4*n +: 4]];
      end
      return r;
   endfunction

   // bit i moves to 16*i mod 63, i.e. {i[1:0], i[5:2]}; bit 63 stays
   function automatic logic [BLOCK_W-1:0] perm_fwd(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] r;
      for (int i = 0; i < BLOCK_W; i++) begin
         r[{i[1:0], i[5:2]}] = s[i];
      end
      return r;
   endfunction

   function automatic logic [BLOCK_W-1:0] perm_inv(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] r;
      for (int i = 0; i < BLOCK_W; i++) begin
         r[i] = s[{i[1:0], i[5:2]}];
      end
      return r;
   endfunction

   function automatic logic [KEY_W-1:0] key_update(input logic [KEY_W-1:0] k,
                                                   input logic [RC_W-1:0]  rc);
      logic [KEY_W-1:0] t;
      t          = {k[18:0], k[KEY_W-1:19]};
      t[79:76]   = SBOX_FWD[t[79:76]];
      t[19:15]   = t[19:15] ^ rc;
      return t;
   endfunction

endpackage

`default_nettype wire

[design/prs80_key_sched.sv]
// Key registers and key schedule: expands the 80-bit key into the round-key file,
// one round key per cycle after reset and after every key write. Uses prs80_pkg.
`default_nettype none

module prs80_key_sched #(
   parameter int ROUND_KEY_COUNT = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [prs80_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [prs80_pkg::BLOCK_W-1:0]       csr_data,
   output logic [prs80_pkg::BLOCK_W-1:0]            rkey_file [ROUND_KEY_COUNT],
   output logic                                     key_ready
);
   import prs80_pkg::*;

   localparam int CNT_W = $clog2(ROUND_KEY_COUNT);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(ROUND_KEY_COUNT - 1);

   logic [BLOCK_W-1:0]  key_low_ff,  key_low_in;
   logic [KEY_HI_W-1:0] key_high_ff, key_high_in;
   logic [KEY_W-1:0]    work_ff,     work_in;
   logic [CNT_W-1:0]    cnt_ff,      cnt_in;
   logic                busy_ff,     busy_in;
   logic [BLOCK_W-1:0]  rk_ff [ROUND_KEY_COUNT];
   logic                wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      if (wr) begin
         unique case (csr_index)
            CSR_KEY_LOW:  key_low_in  = csr_data;
            CSR_KEY_HIGH: key_high_in = csr_data[KEY_HI_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      work_in = work_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (wr) begin
         work_in = {key_high_in, key_low_in};
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = key_update(work_ff, RC_W'(cnt_ff + CNT_W'(1)));
         cnt_in  = cnt_ff + CNT_W'(1);
         busy_in = (cnt_ff != LAST);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         work_ff     <= '0;
         cnt_ff      <= '0;
         busy_ff     <= 1'b1;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
         work_ff     <= work_in;
         cnt_ff      <= cnt_in;
         busy_ff     <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         rk_ff[cnt_ff] <= work_ff[KEY_W-1:KEY_W-BLOCK_W];
      end
   end

   assign rkey_file = rk_ff;
   assign key_ready = !busy_ff;

   a_write_restarts: assert property (@(posedge clock) disable iff (reset)
      wr |=> busy_ff && (cnt_ff == '0))
      else $error("key write did not restart the schedule");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> ($past(cnt_ff) == LAST))
      else $error("key schedule ended before the last round key");

endmodule

`default_nettype wire

[design/prs80_round.sv]
// One pipeline stage: a forward round (key add, S-box, permutation) or an inverse
// round (inverse permutation, inverse S-box, key add), chosen per word. Uses prs80_pkg.
`default_nettype none

module prs80_round (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           enable,
   input  wire prs80_pkg::stage_ctl_type       prev_ctl,
   input  wire logic [prs80_pkg::BLOCK_W-1:0]  prev_state,
   input  wire logic [prs80_pkg::BLOCK_W-1:0]  rk_enc,
   input  wire logic [prs80_pkg::BLOCK_W-1:0]  rk_dec,
   output prs80_pkg::stage_ctl_type            stage_ctl,
   output logic [prs80_pkg::BLOCK_W-1:0]       stage_state
);
   import prs80_pkg::*;

   stage_ctl_type      ctl_ff;
   logic [BLOCK_W-1:0] state_ff, state_in;

   always_comb begin
      if (prev_ctl.mode) begin
         state_in = sub_layer_inv(perm_inv(prev_state)) ^ rk_dec;
      end else begin
         state_in = perm_fwd(sub_layer_fwd(prev_state ^ rk_enc));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (enable) begin
         ctl_ff <= prev_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         state_ff <= state_in;
      end
   end

   assign stage_ctl   = ctl_ff;
   assign stage_state = state_ff;

endmodule

`default_nettype wire

[design/present80_block_cipher.sv]
// PRESENT-80 block cipher top level: key schedule, input stage, round pipeline, output stage.
// Depends on prs80_pkg, prs80_key_sched and prs80_round.
//
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_stall    req_mode, req_block_in
//   rsp_     out        rsp_valid/rsp_stall    rsp_block_out
//   csr_     in         csr_valid/csr_ready    csr_index, csr_data
//
// One word per cycle while req_stall is low. Stages: input stage (key add when decrypting),
// one stage per round, output stage (key add when encrypting).
// After reset and after each key write the schedule fills the round-key file, one key
// per cycle, with req_stall high until it is done. csr_ready is always high.
// rsp_stall with a word waiting freezes the whole pipeline and raises req_stall.
`default_nettype none

module present80_block_cipher #(
   parameter int ROUND_KEY_COUNT = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_mode,
   input  wire logic [prs80_pkg::BLOCK_W-1:0]       req_block_in,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [prs80_pkg::BLOCK_W-1:0]            rsp_block_out,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [prs80_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [prs80_pkg::BLOCK_W-1:0]       csr_data
);
   import prs80_pkg::*;

   localparam int ROUNDS = ROUND_KEY_COUNT - 1;
   localparam int LAST   = ROUND_KEY_COUNT - 1;

   logic [BLOCK_W-1:0] rkey_file [ROUND_KEY_COUNT];
   logic               key_ready;
   logic               enable;

   stage_ctl_type      in_ctl_ff,   in_ctl_in;
   logic [BLOCK_W-1:0] in_state_ff, in_state_in;
   stage_ctl_type      stg_ctl   [ROUNDS+1];
   logic [BLOCK_W-1:0] stg_state [ROUNDS+1];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0] rsp_block_ff, rsp_block_in;

   prs80_key_sched #(
      .ROUND_KEY_COUNT (ROUND_KEY_COUNT)
   ) u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rkey_file  (rkey_file),
      .key_ready  (key_ready)
   );

   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !key_ready || !enable;

   // decrypt starts with the last round key, encrypt ends with it
   always_comb begin
      in_ctl_in.valid = req_valid && key_ready;
      in_ctl_in.mode  = req_mode;
      in_state_in     = req_mode ? (req_block_in ^ rkey_file[LAST]) : req_block_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ctl_ff <= '0;
      end else if (enable) begin
         in_ctl_ff <= in_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         in_state_ff <= in_state_in;
      end
   end

   assign stg_ctl[0]   = in_ctl_ff;
   assign stg_state[0] = in_state_ff;

   for (genvar k = 0; k < ROUNDS; k++) begin : g_round
      prs80_round u_round (
         .clock       (clock),
         .reset       (reset),
         .enable      (enable),
         .prev_ctl    (stg_ctl[k]),
         .prev_state  (stg_state[k]),
         .rk_enc      (rkey_file[k]),
         .rk_dec      (rkey_file[ROUNDS-1-k]),
         .stage_ctl   (stg_ctl[k+1]),
         .stage_state (stg_state[k+1])
      );
   end

   always_comb begin
      rsp_valid_in = stg_ctl[ROUNDS].valid;
      rsp_block_in = stg_ctl[ROUNDS].mode ? stg_state[ROUNDS]
                                          : (stg_state[ROUNDS] ^ rkey_file[LAST]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_block_ff <= rsp_block_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_block_out = rsp_block_ff;

   a_no_accept_while_expanding: assert property (@(posedge clock) disable iff (reset)
      !key_ready |-> req_stall)
      else $error("word accepted while round keys were being expanded");

   a_stall_freezes_pipe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(stg_ctl[0]) && $stable(stg_ctl[ROUNDS]))
      else $error("pipeline moved while the output was stalled");

endmodule

`default_nettype wire
